@@ hdl/bsa_pkg.sv @@
// Shared types, codes and constants for the bitmap slot allocator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bsa_pkg;

  // Default geometry and fixed field widths
  localparam int unsigned DEF_ENTRIES    = 4096;
  localparam int unsigned DEF_POOL_SIZE  = 1024;
  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned RESET_CAPACITY = 4096;
  localparam int unsigned IDX_W          = 12;
  localparam int unsigned CAP_W          = 13;
  localparam int unsigned STATUS_W       = 2;

  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

  // Request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] slot_index;
  } bsa_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    granted_index;
    logic [STATUS_W-1:0] status;
  } bsa_result_t;

  // Entries of one pool that lie below the capacity
  function automatic logic [31:0] pool_init_count(input logic [31:0] cap,
                                                  input logic [31:0] base,
                                                  input logic [31:0] size);
    logic [31:0] n;
    n = 32'd0;
    if (cap > base) begin
      n = cap - base;
      if (n > size) begin
        n = size;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bsa_bitmap_mem.sv @@
// Occupancy bitmap storage: one 32-bit word per address, registered read.
// Per-word valid flags make unwritten words read as all free. Uses bsa_pkg.
`default_nettype none

module bsa_bitmap_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic      [bsa_pkg::WORD_BITS-1:0] rd_data,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [bsa_pkg::WORD_BITS-1:0] wr_data
);
  import bsa_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_valid;

  // Word array: one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Valid flags, dropped at once on reset or restart
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

@@ hdl/bsa_word_scan.sv @@
// Shared word examiner: finds the lowest clear bit of a bitmap word, forms
// the entry index and checks it against the capacity. Uses bsa_pkg.
`default_nettype none

module bsa_word_scan #(
  parameter int unsigned ENTRIES   = 4096,
  parameter int unsigned POOL_SIZE = 1024,
  parameter int unsigned PW        = 2,
  parameter int unsigned WW        = 5,
  parameter int unsigned LW        = 10,
  parameter int unsigned EW        = 13
) (
  input  wire logic [bsa_pkg::WORD_BITS-1:0] word,
  input  wire logic [PW-1:0]                 pool,
  input  wire logic [WW-1:0]                 widx,
  input  wire logic [EW-1:0]                 eff_cap,
  output logic                               all_set,
  output logic      [LW-1:0]                 local_idx,
  output logic      [bsa_pkg::IDX_W-1:0]     entry_idx,
  output logic                               beyond_cap,
  output logic      [bsa_pkg::WORD_BITS-1:0] word_set
);
  import bsa_pkg::*;

  logic [4:0]  bit_sel;
  logic [31:0] local_full;
  logic [31:0] entry_full;

  // Lowest clear bit
  always_comb begin
    bit_sel = 5'd0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        bit_sel = 5'(i);
      end
    end
  end

  assign all_set    = (word == FULL_WORD);
  assign local_full = 32'(widx) * WORD_BITS + 32'(bit_sel);
  assign entry_full = 32'(pool) * POOL_SIZE + local_full;
  assign local_idx  = LW'(local_full);
  assign entry_idx  = IDX_W'(entry_full);
  assign beyond_cap = (entry_full >= 32'(eff_cap));
  assign word_set   = word | (32'd1 << bit_sel);

endmodule

`default_nettype wire

@@ hdl/bitmap_slot_allocator_top.sv @@
// Bitmap slot allocator top level: request sequencer, pool counters/hints.
// Instantiates bsa_bitmap_mem and bsa_word_scan; uses bsa_pkg.
//
// Usage:
//   Request channel: drive req and pulse start; the request is taken at a
//   clock edge where start is high and busy is low. busy stays high until
//   the request is finished. mode allocate takes the lowest free entry,
//   mode free releases req.slot_index.
//   Result channel: done is high for exactly one cycle with result valid;
//   the receiver cannot stall it. The result comes out in the cycle in
//   which busy has already dropped, so a new request may follow at once.
//   A free request reads its bitmap word, then writes back the cleared bit. An
//   allocate skips pools with nothing free, then reads one bitmap word per
//   cycle from the pool's search hint; if every pool is empty it reports full.
//   Configuration: cfg_we writes the capacity (cfg_wdata); the user must do
//   so only while idle, which the block itself does not enforce. It empties
//   the allocator, recomputes pool free counts and clears hints in the same
//   cycle. Reset does the same with a capacity of 4096.
`default_nettype none

module bitmap_slot_allocator_top #(
  parameter int unsigned ENTRIES   = bsa_pkg::DEF_ENTRIES,
  parameter int unsigned POOL_SIZE = bsa_pkg::DEF_POOL_SIZE
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire bsa_pkg::bsa_req_t         req,
  output logic                           done,
  output bsa_pkg::bsa_result_t           result,
  input  wire logic                      cfg_we,
  input  wire logic [bsa_pkg::CAP_W-1:0] cfg_wdata
);
  import bsa_pkg::*;

  localparam int unsigned NPOOLS = (ENTRIES + POOL_SIZE - 1) / POOL_SIZE;
  localparam int unsigned WPP    = POOL_SIZE / WORD_BITS;
  localparam int unsigned NWORDS = NPOOLS * WPP;
  localparam int unsigned PW     = (NPOOLS > 1) ? $clog2(NPOOLS) : 1;
  localparam int unsigned PCW    = $clog2(NPOOLS + 1);
  localparam int unsigned WW     = (WPP > 1) ? $clog2(WPP) : 1;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned LW     = $clog2(POOL_SIZE);
  localparam int unsigned CNTW   = $clog2(POOL_SIZE + 1);
  localparam int unsigned EW     = $clog2(ENTRIES + 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POOL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FREE = 2'd3;

  logic [1:0]      state, state_next;
  logic [PCW-1:0]  pool_ctr, pool_ctr_next;
  logic [WW-1:0]   word_ctr, word_ctr_next;
  logic [PW-1:0]   free_pool;
  logic [LW-1:0]   free_local;
  logic            free_ok;
  logic [EW-1:0]   eff_cap;
  logic [CNTW-1:0] free_count [NPOOLS];
  logic [LW-1:0]   hint       [NPOOLS];
  logic            done_next;
  bsa_result_t     result_next;

  logic [31:0]     cap_src;
  logic [EW-1:0]   eff_src;
  logic [PW-1:0]   pool_sel;
  logic [LW-1:0]   hint_sel;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic            scan_all_set;
  logic [LW-1:0]   scan_local;
  logic [IDX_W-1:0] scan_entry;
  logic            scan_beyond;
  logic [WORD_BITS-1:0] scan_word_set;

  logic            cnt_dec, cnt_inc, hint_wr;
  logic [PW-1:0]   upd_pool;
  logic [LW-1:0]   hint_val;

  logic            accept;
  logic            in_range;

  bsa_bitmap_mem #(
    .DEPTH (NWORDS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (cfg_we),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bsa_word_scan #(
    .ENTRIES   (ENTRIES),
    .POOL_SIZE (POOL_SIZE),
    .PW        (PW),
    .WW        (WW),
    .LW        (LW),
    .EW        (EW)
  ) u_scan (
    .word       (rd_data),
    .pool       (pool_sel),
    .widx       (word_ctr),
    .eff_cap    (eff_cap),
    .all_set    (scan_all_set),
    .local_idx  (scan_local),
    .entry_idx  (scan_entry),
    .beyond_cap (scan_beyond),
    .word_set   (scan_word_set)
  );

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign pool_sel = pool_ctr[PW-1:0];
  assign hint_sel = hint[pool_sel];
  assign in_range = (32'(req.slot_index) < 32'(eff_cap));

  // Capacity in effect after reset or a write, clipped to the table size
  always_comb begin
    cap_src = rst ? 32'(RESET_CAPACITY) : 32'(cfg_wdata);
    eff_src = (cap_src > 32'(ENTRIES)) ? EW'(ENTRIES) : EW'(cap_src);
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    pool_ctr_next = pool_ctr;
    word_ctr_next = word_ctr;
    done_next     = 1'b0;
    result_next   = '{granted_index: '0, status: ST_OK};
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = AW'(32'(pool_sel) * WPP + 32'(word_ctr));
    wr_data       = scan_word_set;
    cnt_dec       = 1'b0;
    cnt_inc       = 1'b0;
    hint_wr       = 1'b0;
    hint_val      = '0;
    upd_pool      = pool_sel;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.mode == MODE_FREE) begin
            rd_en      = in_range;
            rd_addr    = AW'(32'(req.slot_index) >> 5);
            state_next = S_FREE;
          end else begin
            pool_ctr_next = '0;
            state_next    = S_POOL;
          end
        end
      end

      // Skip pools with nothing free, then read the hinted word; report full once every pool is passed
      S_POOL: begin
        if (32'(pool_ctr) >= 32'(NPOOLS)) begin
          done_next          = 1'b1;
          result_next.status = ST_FULL;
          state_next         = S_IDLE;
        end else if (free_count[pool_sel] == '0) begin
          pool_ctr_next = pool_ctr + 1'b1;
        end else begin
          word_ctr_next = WW'(32'(hint_sel) >> 5);
          rd_en         = 1'b1;
          rd_addr       = AW'(32'(pool_sel) * WPP + (32'(hint_sel) >> 5));
          state_next    = S_SCAN;
        end
      end

      // One bitmap word per cycle; grant its lowest clear bit, or report full if that lies beyond the capacity
      S_SCAN: begin
        if (scan_all_set) begin
          if (32'(word_ctr) == WPP - 1) begin
            pool_ctr_next = pool_ctr + 1'b1;
            state_next    = S_POOL;
          end else begin
            word_ctr_next = word_ctr + 1'b1;
            rd_en         = 1'b1;
            rd_addr       = AW'(32'(pool_sel) * WPP + 32'(word_ctr) + 32'd1);
          end
        end else if (scan_beyond) begin
          done_next          = 1'b1;
          result_next.status = ST_FULL;
          state_next         = S_IDLE;
        end else begin
          wr_en   = 1'b1;
          cnt_dec = 1'b1;
          if (hint_sel == scan_local) begin
            hint_wr  = 1'b1;
            hint_val = (32'(scan_local) + 32'd1 >= 32'(POOL_SIZE)) ? '0 : scan_local + 1'b1;
          end
          done_next                 = 1'b1;
          result_next.granted_index = scan_entry;
          state_next                = S_IDLE;
        end
      end

      // Check and clear the released bit
      S_FREE: begin
        upd_pool = free_pool;
        wr_addr  = AW'(32'(free_pool) * WPP + (32'(free_local) >> 5));
        wr_data  = rd_data & ~(32'd1 << free_local[4:0]);
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (!free_ok || !rd_data[free_local[4:0]]) begin
          result_next.status = ST_BAD_FREE;
        end else begin
          wr_en   = 1'b1;
          cnt_inc = 1'b1;
          if (free_local < hint[free_pool]) begin
            hint_wr  = 1'b1;
            hint_val = free_local;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      pool_ctr <= '0;
      word_ctr <= '0;
    end else begin
      state    <= state_next;
      done     <= done_next;
      pool_ctr <= pool_ctr_next;
      word_ctr <= word_ctr_next;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    result <= result_next;
    if (accept) begin
      free_pool  <= PW'(32'(req.slot_index) >> LW);
      free_local <= LW'(req.slot_index);
      free_ok    <= in_range;
    end
  end

  // Pool free counts, hints and capacity; restart on reset or write
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      eff_cap <= eff_src;
      for (int i = 0; i < NPOOLS; i++) begin
        free_count[i] <= CNTW'(pool_init_count(32'(eff_src), 32'(i) * POOL_SIZE,
                                               32'(POOL_SIZE)));
        hint[i]       <= '0;
      end
    end else begin
      if (cnt_dec) begin
        free_count[upd_pool] <= free_count[upd_pool] - 1'b1;
      end
      if (cnt_inc) begin
        free_count[upd_pool] <= free_count[upd_pool] + 1'b1;
      end
      if (hint_wr) begin
        hint[upd_pool] <= hint_val;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/bsa_checker.sv @@
// Port-level checks for the bitmap slot allocator, bound to its top level.
// Sees only the top level's ports; uses bsa_pkg.
`default_nettype none

module bsa_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 done,
  input wire bsa_pkg::bsa_result_t result
);
  import bsa_pkg::*;

  // A result is only shown once the request has finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // An accepted request holds the block busy, with no result, in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not occupy the block");

  // Failed requests never report an index
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.granted_index == '0))
    else $error("nonzero index on a failed request");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_FULL ||
              result.status == ST_BAD_FREE))
    else $error("undefined status code");

  // Busy only rises because a request was taken
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind bitmap_slot_allocator_top bsa_checker u_bsa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
